// ===== hw/rtl/float32_add_reduced_precision_top_macros.svh =====
// Assertion macros for the reduced-precision float adder.
`ifndef FLOAT32_ADD_REDUCED_PRECISION_TOP_MACROS_SVH
`define FLOAT32_ADD_REDUCED_PRECISION_TOP_MACROS_SVH
// Implication checked on every clock edge outside reset.
`define FAR_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);
// Next-cycle implication checked outside reset.
`define FAR_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`endif

// ===== hw/rtl/far_pkg.sv =====
// Package for the reduced-precision float adder: widths and constants.
package far_pkg;
    localparam int MANT_W = 24;
    localparam int FRAC_W = 23;
    localparam int EXP_W = 8;
    localparam int PREC_W = 5;
    localparam logic [PREC_W-1:0] PREC_RESET = 5'd23;
    localparam logic [PREC_W-1:0] PREC_MAX = 5'd23;
    localparam int STAGES = 4;
endpackage

// ===== hw/rtl/far_lzc.sv =====
// Leading-zero count of a 25-bit mantissa, two-level.
module far_lzc
(
    input  logic [24:0] value,
    output logic [4:0]  count
);
    logic [4:0] hi_cnt;
    logic [4:0] lo_cnt;
    logic       hi_zero;

    // upper 13 bits, then lower 12 bits
    always_comb
    begin
        hi_cnt = 5'd13;
        for (int i = 0; i < 13; i++)
        begin
            if (value[12 + i])
            begin
                hi_cnt = 5'(12 - i);
            end
        end
        lo_cnt = 5'd12;
        for (int j = 0; j < 12; j++)
        begin
            if (value[j])
            begin
                lo_cnt = 5'(11 - j);
            end
        end
        hi_zero = (value[24:12] == 13'd0);
        count = hi_zero ? 5'(hi_cnt + lo_cnt) : hi_cnt;
    end
endmodule

// ===== hw/rtl/float32_add_reduced_precision_top.sv =====
// Top level of the reduced-precision float adder: four-stage pipeline.
// Throughput: one transaction per cycle; all four stages hold together on a stall.
// Stages: align, add/subtract, leading-zero count, normalize and mask.
// Reset (rst_n, asynchronous, active low) clears valid bits; precision returns to 23.
// Output ready low while a result is valid holds the whole pipeline.
`include "float32_add_reduced_precision_top_macros.svh"
module float32_add_reduced_precision_top
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        cfg_we,
    input  logic [4:0]  cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [63:0] s_tdata,   // operand_a[31:0], operand_b[63:32]
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata    // sum_word[31:0]
);
    localparam int STAGES = far_pkg::STAGES;

    logic [far_pkg::PREC_W-1:0] prec_reg;
    logic [STAGES-1:0] vld_reg;
    logic adv;

    // pipeline advances when the output is free or taken
    assign adv = !vld_reg[STAGES-1] || m_tready;
    assign s_tready = adv;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prec_reg <= far_pkg::PREC_RESET;
            vld_reg <= '0;
        end
        else
        begin
            if (cfg_we)
            begin
                prec_reg <= cfg_wdata;
            end
            if (adv)
            begin
                vld_reg <= {vld_reg[STAGES-2:0], s_tvalid};
            end
        end
    end

    // stage 1: unpack and align
    logic [31:0] a, b;
    logic a_zero, b_zero;
    logic [7:0] ae, be;
    logic [8:0] d_ab, d_ba;
    logic [23:0] am, bm, am_s, bm_s;
    assign a = s_tdata[31:0];
    assign b = s_tdata[63:32];
    assign ae = a[30:23];
    assign be = b[30:23];
    assign a_zero = (a[30:0] == 31'd0);
    assign b_zero = (b[30:0] == 31'd0);
    assign am = {1'b1, a[22:0]};
    assign bm = {1'b1, b[22:0]};
    assign d_ab = {1'b0, ae} - {1'b0, be};
    assign d_ba = {1'b0, be} - {1'b0, ae};

    always_comb
    begin
        am_s = am;
        bm_s = bm;
        if (ae > be)
        begin
            bm_s = (d_ab >= 9'd24) ? 24'd0 : (bm >> d_ab[4:0]);
        end
        else if (be > ae)
        begin
            am_s = (d_ba >= 9'd24) ? 24'd0 : (am >> d_ba[4:0]);
        end
    end

    logic        s1_byp_reg;
    logic [31:0] s1_bw_reg;
    logic        s1_as_reg, s1_bs_reg;
    logic [7:0]  s1_e_reg;
    logic [23:0] s1_am_reg, s1_bm_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s1_byp_reg <= a_zero || b_zero;
            s1_bw_reg  <= a_zero ? b : a;
            s1_as_reg  <= a[31];
            s1_bs_reg  <= b[31];
            s1_e_reg   <= (ae > be) ? ae : be;
            s1_am_reg  <= am_s;
            s1_bm_reg  <= bm_s;
        end
    end

    // stage 2: add or subtract magnitudes
    logic [24:0] pos, neg, sum_mag;
    logic sgn;
    logic same;
    assign same = (s1_as_reg == s1_bs_reg);
    assign pos = {1'b0, s1_as_reg ? s1_bm_reg : s1_am_reg};
    assign neg = {1'b0, s1_as_reg ? s1_am_reg : s1_bm_reg};
    always_comb
    begin
        if (same)
        begin
            sgn = s1_as_reg;
            sum_mag = {1'b0, s1_am_reg} + {1'b0, s1_bm_reg};
        end
        else if (pos >= neg)
        begin
            sgn = 1'b0;
            sum_mag = pos - neg;
        end
        else
        begin
            sgn = 1'b1;
            sum_mag = neg - pos;
        end
    end

    logic        s2_byp_reg;
    logic [31:0] s2_bw_reg;
    logic        s2_s_reg;
    logic [7:0]  s2_e_reg;
    logic [24:0] s2_m_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s2_byp_reg <= s1_byp_reg;
            s2_bw_reg  <= s1_bw_reg;
            s2_s_reg   <= sgn;
            s2_e_reg   <= s1_e_reg;
            s2_m_reg   <= sum_mag;
        end
    end

    // stage 3: leading-zero count
    logic [4:0] lz;
    far_lzc u_lzc
    (
        .value (s2_m_reg),
        .count (lz)
    );

    logic        s3_byp_reg;
    logic [31:0] s3_bw_reg;
    logic        s3_s_reg;
    logic [7:0]  s3_e_reg;
    logic [24:0] s3_m_reg;
    logic [4:0]  s3_lz_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            s3_byp_reg <= s2_byp_reg;
            s3_bw_reg  <= s2_bw_reg;
            s3_s_reg   <= s2_s_reg;
            s3_e_reg   <= s2_e_reg;
            s3_m_reg   <= s2_m_reg;
            s3_lz_reg  <= lz;
        end
    end

    // stage 4: normalize, zero check, precision mask, zero-operand bypass
    logic [24:0] nm;
    logic [7:0]  ne;
    logic [4:0]  p;
    logic [23:0] mask;
    logic [31:0] res;
    always_comb
    begin
        nm = s3_m_reg;
        ne = s3_e_reg;
        if (s3_m_reg[24])
        begin
            nm = s3_m_reg >> 1;
            ne = s3_e_reg + 8'd1;
        end
        else if (s3_m_reg != 25'd0)
        begin
            // lz counts from bit 24; one zero is the normal position
            nm = s3_m_reg << (s3_lz_reg - 5'd1);
            ne = s3_e_reg - 8'(s3_lz_reg - 5'd1);
        end
        if (s3_m_reg == 25'd0)
        begin
            ne = 8'd0;
        end
        p = (prec_reg > far_pkg::PREC_MAX) ? far_pkg::PREC_MAX : prec_reg;
        mask = 24'hFFFFFF << (5'd23 - p);
        res = {s3_s_reg, ne, nm[22:0] & mask[22:0]};
    end

    logic [31:0] out_reg;
    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            out_reg <= s3_byp_reg ? s3_bw_reg : res;
        end
    end

    assign m_tvalid = vld_reg[STAGES-1];
    assign m_tdata  = out_reg;

    `FAR_ASSERT_IMP(a_ready_free, clk, rst_n, !m_tvalid, s_tready, "ready low with empty output")
    `FAR_ASSERT_NEXT(a_hold, clk, rst_n, m_tvalid && !m_tready, m_tvalid && $stable(m_tdata),
        "result changed while stalled")
    `FAR_ASSERT_NEXT(a_flow, clk, rst_n, s_tvalid && s_tready, vld_reg[0],
        "accepted transaction lost")
endmodule
